/* hw/rtl/ace_pkg.sv */
// shared types, codes and defaults of the ansi csi console engine
`default_nettype none
package ace_pkg;

    localparam int MAX_ARGS_DEF   = 15;
    localparam int MAX_DIGITS_DEF = 4;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET = 8'd25;
    localparam logic [6:0] ATTR_RESET = 7'h07;

    // configuration register indexes
    localparam logic [7:0] REG_COLUMNS = 8'd0;
    localparam logic [7:0] REG_ROWS    = 8'd1;

    // token kinds from the parser
    localparam logic [1:0] TOK_PEND = 2'd0;
    localparam logic [1:0] TOK_REJ  = 2'd1;
    localparam logic [1:0] TOK_EXEC = 2'd2;

    // command classes
    localparam logic [3:0] CMD_POS       = 4'd0;
    localparam logic [3:0] CMD_UP        = 4'd1;
    localparam logic [3:0] CMD_DOWN      = 4'd2;
    localparam logic [3:0] CMD_RIGHT     = 4'd3;
    localparam logic [3:0] CMD_LEFT      = 4'd4;
    localparam logic [3:0] CMD_NEXT_LINE = 4'd5;
    localparam logic [3:0] CMD_PREV_LINE = 4'd6;
    localparam logic [3:0] CMD_COLUMN    = 4'd7;
    localparam logic [3:0] CMD_ERASE_SCR = 4'd8;
    localparam logic [3:0] CMD_ERASE_LN  = 4'd9;
    localparam logic [3:0] CMD_SGR       = 4'd10;
    localparam logic [3:0] CMD_SHOW      = 4'd11;
    localparam logic [3:0] CMD_HIDE      = 4'd12;
    localparam logic [3:0] CMD_NOP       = 4'd13;
    localparam logic [3:0] CMD_REPORT    = 4'd14;
    localparam logic [3:0] CMD_BAD       = 4'd15;

    localparam logic [1:0] PREFIX_NONE  = 2'd0;
    localparam logic [1:0] PREFIX_QUERY = 2'd1;
    localparam logic [1:0] PREFIX_EQ    = 2'd2;

    localparam logic [1:0] STATUS_PEND = 2'd0;
    localparam logic [1:0] STATUS_EXEC = 2'd1;
    localparam logic [1:0] STATUS_REJ  = 2'd2;

    localparam logic [2:0] CLR_NONE = 3'd0;
    localparam logic [2:0] CLR_SCR  = 3'd1;
    localparam logic [2:0] CLR_LN   = 3'd4;

    typedef struct packed {
        logic [7:0] cols;
        logic [7:0] rows;
    } screen_cfg_t;

endpackage
`default_nettype wire

/* hw/rtl/ace_ifs.sv */
// stream and configuration interfaces of the console engine
`default_nettype none
interface ace_char_if;
    logic        valid;
    logic        ready;
    logic [15:0] ch;
    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

interface ace_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] cursor_row;
    logic [7:0] cursor_col;
    logic [6:0] text_attr;
    logic       cursor_visible;
    logic [2:0] clear_op;
    logic       report_valid;
    modport source (output valid, output status, output cursor_row, output cursor_col,
                    output text_attr, output cursor_visible, output clear_op,
                    output report_valid, input ready);
    modport sink (input valid, input status, input cursor_row, input cursor_col,
                  input text_attr, input cursor_visible, input clear_op,
                  input report_valid, output ready);
endinterface

interface ace_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ace_fifo.sv */
// small register queue between parser and executor
`default_nettype none
module ace_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ace_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/ace_front.sv */
// parser: takes characters, gathers arguments and classifies the command
`default_nettype none
module ace_front #(
    parameter int MAX_ARGS   = ace_pkg::MAX_ARGS_DEF,
    parameter int MAX_DIGITS = ace_pkg::MAX_DIGITS_DEF,
    localparam int IDX_W = $clog2(MAX_ARGS),
    localparam int CNT_W = $clog2(MAX_ARGS + 1),
    localparam int ARG_W = $clog2(10 ** MAX_DIGITS),
    localparam int TOK_W = 9 + IDX_W + ARG_W + CNT_W
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ace_char_if.sink   char_in,
    output logic       push,
    output logic [TOK_W-1:0] push_data,
    input  wire logic  full
);
    localparam int DC_W = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_PARSE = 2'd1;
    localparam logic [1:0] PH_NUM   = 2'd2;

    localparam logic [15:0] CH_LBRACK = 16'h005B;
    localparam logic [15:0] CH_QUERY  = 16'h003F;
    localparam logic [15:0] CH_EQ     = 16'h003D;
    localparam logic [15:0] CH_SEMI   = 16'h003B;
    localparam logic [15:0] CH_ZERO   = 16'h0030;
    localparam logic [15:0] CH_NINE   = 16'h0039;

    typedef struct packed {
        logic [1:0]       kind;
        logic [3:0]       cmd;
        logic [1:0]       prefix;
        logic             we;
        logic [IDX_W-1:0] widx;
        logic [ARG_W-1:0] wval;
        logic [CNT_W-1:0] cnt;
    } token_t;

    function automatic logic [3:0] classify(input logic [15:0] c);
        logic [3:0] k;
        case (c)
            16'h0048, 16'h0066: k = ace_pkg::CMD_POS;
            16'h0041: k = ace_pkg::CMD_UP;
            16'h0042: k = ace_pkg::CMD_DOWN;
            16'h0043: k = ace_pkg::CMD_RIGHT;
            16'h0044: k = ace_pkg::CMD_LEFT;
            16'h0045: k = ace_pkg::CMD_NEXT_LINE;
            16'h0046: k = ace_pkg::CMD_PREV_LINE;
            16'h0047: k = ace_pkg::CMD_COLUMN;
            16'h004A: k = ace_pkg::CMD_ERASE_SCR;
            16'h004B: k = ace_pkg::CMD_ERASE_LN;
            16'h006D: k = ace_pkg::CMD_SGR;
            16'h0068: k = ace_pkg::CMD_SHOW;
            16'h006C: k = ace_pkg::CMD_HIDE;
            16'h0073, 16'h0075: k = ace_pkg::CMD_NOP;
            16'h006E: k = ace_pkg::CMD_REPORT;
            default: k = ace_pkg::CMD_BAD;
        endcase
        return k;
    endfunction

    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [DC_W-1:0]  dcnt_reg, dcnt_next;
    logic [1:0]       prefix_reg, prefix_next;
    logic [ARG_W-1:0] acc_reg, acc_next;
    logic [ARG_W-1:0] digit;
    logic [ARG_W+3:0] acc_mul;
    logic [3:0]       cmd;
    logic             is_digit, accept;
    token_t           tok;

    assign char_in.ready = !full;
    assign accept    = char_in.valid && !full;
    assign push      = accept;
    assign push_data = tok;

    assign is_digit = (char_in.ch >= CH_ZERO) && (char_in.ch <= CH_NINE);
    assign digit    = ARG_W'(char_in.ch[3:0]);
    assign acc_mul  = (ARG_W + 4)'(acc_reg) * (ARG_W + 4)'(10) + (ARG_W + 4)'(digit);
    assign cnt_inc  = cnt_reg + 1'b1;
    assign cmd      = classify(char_in.ch);

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        dcnt_next   = dcnt_reg;
        prefix_next = prefix_reg;
        acc_next    = acc_reg;
        tok.kind    = ace_pkg::TOK_PEND;
        tok.cmd     = cmd;
        tok.prefix  = prefix_reg;
        tok.we      = 1'b0;
        tok.widx    = cnt_reg[IDX_W-1:0];
        tok.wval    = acc_reg;
        tok.cnt     = cnt_reg;
        if (char_in.ch != 16'h0000)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (char_in.ch == CH_LBRACK)
                    begin
                        phase_next = PH_PARSE;
                    end
                    else
                    begin
                        tok.kind = ace_pkg::TOK_REJ;
                    end
                end
                PH_PARSE:
                begin
                    if (is_digit)
                    begin
                        phase_next = PH_NUM;
                        dcnt_next  = DC_W'(1);
                        acc_next   = digit;
                    end
                    else if (char_in.ch == CH_QUERY)
                    begin
                        prefix_next = ace_pkg::PREFIX_QUERY;
                    end
                    else if (char_in.ch == CH_EQ)
                    begin
                        prefix_next = ace_pkg::PREFIX_EQ;
                    end
                    else
                    begin
                        tok.kind = (cmd == ace_pkg::CMD_BAD) ? ace_pkg::TOK_REJ
                                                             : ace_pkg::TOK_EXEC;
                    end
                end
                PH_NUM:
                begin
                    if (is_digit)
                    begin
                        if (dcnt_reg < DC_W'(MAX_DIGITS))
                        begin
                            acc_next  = acc_mul[ARG_W-1:0];
                            dcnt_next = dcnt_reg + 1'b1;
                        end
                        else
                        begin
                            tok.kind = ace_pkg::TOK_REJ;
                        end
                    end
                    else if (char_in.ch == CH_SEMI)
                    begin
                        dcnt_next = '0;
                        acc_next  = '0;
                        cnt_next  = cnt_inc;
                        if (cnt_inc >= CNT_W'(MAX_ARGS))
                        begin
                            tok.kind = ace_pkg::TOK_REJ;
                        end
                        else
                        begin
                            tok.we = 1'b1;
                        end
                    end
                    else
                    begin
                        tok.we   = 1'b1;
                        tok.cnt  = cnt_inc;
                        tok.kind = (cmd == ace_pkg::CMD_BAD) ? ace_pkg::TOK_REJ
                                                             : ace_pkg::TOK_EXEC;
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
            // any verdict ends the sequence
            if (tok.kind != ace_pkg::TOK_PEND)
            begin
                phase_next  = PH_START;
                cnt_next    = '0;
                dcnt_next   = '0;
                prefix_next = ace_pkg::PREFIX_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            cnt_reg    <= '0;
            dcnt_reg   <= '0;
            prefix_reg <= ace_pkg::PREFIX_NONE;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            dcnt_reg   <= dcnt_next;
            prefix_reg <= prefix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acc_reg <= acc_next;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/ace_back.sv */
// executor: applies commands to cursor, attribute and visibility state
`default_nettype none
module ace_back #(
    parameter int MAX_ARGS   = ace_pkg::MAX_ARGS_DEF,
    parameter int MAX_DIGITS = ace_pkg::MAX_DIGITS_DEF,
    localparam int IDX_W = $clog2(MAX_ARGS),
    localparam int CNT_W = $clog2(MAX_ARGS + 1),
    localparam int ARG_W = $clog2(10 ** MAX_DIGITS),
    localparam int TOK_W = 9 + IDX_W + ARG_W + CNT_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ace_pkg::screen_cfg_t cfg,
    output logic                   pop,
    input  wire logic [TOK_W-1:0]  pop_data,
    input  wire logic              empty,
    ace_result_if.source           result
);
    localparam int SW = ((ARG_W > 8) ? ARG_W : 8) + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [3:0]       cmd;
        logic [1:0]       prefix;
        logic             we;
        logic [IDX_W-1:0] widx;
        logic [ARG_W-1:0] wval;
        logic [CNT_W-1:0] cnt;
    } token_t;

    function automatic logic [6:0] sgr_apply(input logic [6:0] a, input logic [31:0] v);
        logic [3:0] fg;
        logic [2:0] bg;
        logic [6:0] r;
        case (v[2:0])
            3'd0: fg = 4'h0;
            3'd1: fg = 4'h4;
            3'd2: fg = 4'h2;
            3'd3: fg = 4'he;
            3'd4: fg = 4'h1;
            3'd5: fg = 4'h5;
            3'd6: fg = 4'h3;
            default: fg = 4'hf;
        endcase
        // the color index is v minus a multiple of ten; rebase by the tens range
        case (v) inside
            [32'd30:32'd37]:   fg = sgr_fg(v - 32'd30);
            [32'd90:32'd97]:   fg = sgr_fg(v - 32'd90);
            default: ;
        endcase
        bg = 3'd0;
        case (v) inside
            [32'd40:32'd47]:   bg = sgr_bg(v - 32'd40);
            [32'd100:32'd107]: bg = sgr_bg(v - 32'd100);
            default: ;
        endcase
        case (v) inside
            32'd0:                             r = ace_pkg::ATTR_RESET;
            32'd1:                             r = a | 7'h08;
            32'd2, 32'd22:                     r = a & ~7'h08;
            32'd7, 32'd27:                     r = ~a;
            [32'd30:32'd37]:                   r = (a & 7'h78) | {3'd0, fg};
            32'd39:                            r = (a & 7'h70) | 7'h07;
            [32'd40:32'd47], [32'd100:32'd107]: r = (a & 7'h0f) | {bg, 4'h0};
            32'd49:                            r = a & 7'h0f;
            [32'd90:32'd97]:                   r = (a & 7'h70) | 7'h08 | {3'd0, fg};
            default:                           r = a;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] sgr_fg(input logic [31:0] i);
        logic [3:0] f;
        case (i[2:0])
            3'd0: f = 4'h0;
            3'd1: f = 4'h4;
            3'd2: f = 4'h2;
            3'd3: f = 4'he;
            3'd4: f = 4'h1;
            3'd5: f = 4'h5;
            3'd6: f = 4'h3;
            default: f = 4'hf;
        endcase
        return f;
    endfunction

    function automatic logic [2:0] sgr_bg(input logic [31:0] i);
        logic [2:0] b;
        case (i[2:0])
            3'd0: b = 3'd0;
            3'd1: b = 3'd4;
            3'd2: b = 3'd2;
            3'd3: b = 3'd6;
            3'd4: b = 3'd1;
            3'd5: b = 3'd5;
            3'd6: b = 3'd3;
            default: b = 3'd7;
        endcase
        return b;
    endfunction

    token_t           tok;
    logic [1:0]       state_reg, state_next;
    logic [ARG_W-1:0] arg_reg [MAX_ARGS];
    logic [IDX_W-1:0] wi_reg, wi_next;
    logic [CNT_W-1:0] wcnt_reg, wcnt_next;
    logic [7:0]       row_reg, row_next, col_reg, col_next;
    logic [6:0]       attr_reg, attr_next;
    logic             vis_reg, vis_next;

    logic             ovalid_reg, ovalid_next;
    logic [1:0]       ostatus_reg, ostatus_next;
    logic [7:0]       orow_reg, orow_next, ocol_reg, ocol_next;
    logic [6:0]       oattr_reg, oattr_next;
    logic             ovis_reg, ovis_next;
    logic [2:0]       oclr_reg, oclr_next;
    logic             orep_reg, orep_next;

    logic             slot_free, take;
    logic [ARG_W-1:0] a0, a1;
    logic [SW-1:0]    d, g, rowx, colx, effr, effc, lastr, lastc, tr, tc;
    logic [7:0]       effr8, effc8;
    logic             move, rej;
    logic [1:0]       st;
    logic [2:0]       clr;
    logic             rep;

    assign tok       = token_t'(pop_data);
    assign slot_free = !ovalid_reg || result.ready;
    assign take      = (state_reg == ST_IDLE) && !empty && slot_free;
    assign pop       = take;

    assign a0 = (tok.we && tok.widx == IDX_W'(0)) ? tok.wval : arg_reg[0];
    assign a1 = (tok.we && tok.widx == IDX_W'(1)) ? tok.wval : arg_reg[1];

    assign effr8 = (cfg.rows == 8'd0) ? 8'd1 : cfg.rows;
    assign effc8 = (cfg.cols == 8'd0) ? 8'd1 : cfg.cols;
    assign effr  = SW'(effr8);
    assign effc  = SW'(effc8);
    assign lastr = effr - 1'b1;
    assign lastc = effc - 1'b1;
    assign rowx  = SW'(row_reg);
    assign colx  = SW'(col_reg);
    assign g     = (d > '0) ? d - 1'b1 : '0;

    // command decode for the token at the head of the queue
    always_comb
    begin
        d    = SW'(1);
        rej  = 1'b0;
        move = 1'b0;
        tr   = rowx;
        tc   = colx;
        clr  = ace_pkg::CLR_NONE;
        rep  = 1'b0;
        vis_next = vis_reg;
        if (tok.cnt == CNT_W'(1))
        begin
            d = SW'(a0);
        end
        else if (tok.cnt != '0 && tok.cmd >= ace_pkg::CMD_UP &&
                 tok.cmd <= ace_pkg::CMD_COLUMN)
        begin
            rej = 1'b1;
        end
        unique case (tok.cmd)
            ace_pkg::CMD_POS:
            begin
                move = 1'b1;
                if (tok.cnt == '0)
                begin
                    tr = '0;
                    tc = '0;
                end
                else if (tok.cnt == CNT_W'(2))
                begin
                    tr = SW'(a0);
                    tc = SW'(a1);
                end
                else
                begin
                    rej = 1'b1;
                end
            end
            ace_pkg::CMD_UP:
            begin
                move = 1'b1;
                tr = (rowx > d) ? rowx - d : '0;
            end
            ace_pkg::CMD_DOWN:
            begin
                move = 1'b1;
                tr = (rowx + d < lastr) ? rowx + d : lastr;
            end
            ace_pkg::CMD_RIGHT:
            begin
                move = 1'b1;
                tc = (colx + d < lastc) ? colx + d : lastc;
            end
            ace_pkg::CMD_LEFT:
            begin
                move = 1'b1;
                tc = (colx > d) ? colx - d : '0;
            end
            ace_pkg::CMD_NEXT_LINE:
            begin
                move = 1'b1;
                tc = '0;
                tr = (rowx + d < lastr) ? rowx + d : lastr;
            end
            ace_pkg::CMD_PREV_LINE:
            begin
                move = 1'b1;
                tc = '0;
                tr = (rowx > d) ? rowx - d : '0;
            end
            ace_pkg::CMD_COLUMN:
            begin
                move = 1'b1;
                tc = (g < lastc) ? g : lastc;
            end
            ace_pkg::CMD_ERASE_SCR, ace_pkg::CMD_ERASE_LN:
            begin
                if (tok.cnt != '0 && a0 > ARG_W'(2))
                begin
                    rej = 1'b1;
                end
                else
                begin
                    clr = ((tok.cnt == '0) ? 3'd0 : a0[2:0]) +
                          ((tok.cmd == ace_pkg::CMD_ERASE_SCR) ? ace_pkg::CLR_SCR
                                                               : ace_pkg::CLR_LN);
                end
            end
            ace_pkg::CMD_SGR:
            begin
                rej = (tok.cnt == '0);
            end
            ace_pkg::CMD_SHOW, ace_pkg::CMD_HIDE:
            begin
                if (tok.prefix == ace_pkg::PREFIX_QUERY && tok.cnt == CNT_W'(1) &&
                    a0 == ARG_W'(25))
                begin
                    vis_next = (tok.cmd == ace_pkg::CMD_SHOW);
                end
            end
            ace_pkg::CMD_NOP:
            begin
            end
            ace_pkg::CMD_REPORT:
            begin
                if (tok.cnt == CNT_W'(1) && a0 == ARG_W'(6))
                begin
                    rep = 1'b1;
                end
                else
                begin
                    rej = 1'b1;
                end
            end
            ace_pkg::CMD_BAD:
            begin
                rej = 1'b1;
            end
            default:
            begin
                rej = 1'b1;
            end
        endcase
        if (rej)
        begin
            move = 1'b0;
            clr  = ace_pkg::CLR_NONE;
            rep  = 1'b0;
            vis_next = vis_reg;
        end
        st = rej ? ace_pkg::STATUS_REJ : ace_pkg::STATUS_EXEC;
    end

    always_comb
    begin
        state_next   = state_reg;
        wi_next      = wi_reg;
        wcnt_next    = wcnt_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        attr_next    = attr_reg;
        ovalid_next  = ovalid_reg && !result.ready;
        ostatus_next = ostatus_reg;
        orow_next    = orow_reg;
        ocol_next    = ocol_reg;
        oattr_next   = oattr_reg;
        ovis_next    = ovis_reg;
        oclr_next    = oclr_reg;
        orep_next    = orep_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    ovalid_next  = 1'b1;
                    oclr_next    = ace_pkg::CLR_NONE;
                    orep_next    = 1'b0;
                    ostatus_next = ace_pkg::STATUS_PEND;
                    if (tok.kind == ace_pkg::TOK_REJ)
                    begin
                        ostatus_next = ace_pkg::STATUS_REJ;
                    end
                    else if (tok.kind == ace_pkg::TOK_EXEC)
                    begin
                        if (tok.cmd == ace_pkg::CMD_SGR && !rej)
                        begin
                            ovalid_next = 1'b0;
                            wi_next     = '0;
                            wcnt_next   = tok.cnt;
                            state_next  = ST_WALK;
                        end
                        else
                        begin
                            ostatus_next = st;
                            oclr_next    = clr;
                            orep_next    = rep;
                            if (move && tc < effc && tr < effr)
                            begin
                                row_next = tr[7:0];
                                col_next = tc[7:0];
                            end
                        end
                    end
                    orow_next  = row_next;
                    ocol_next  = col_next;
                    oattr_next = attr_reg;
                    ovis_next  = (tok.kind == ace_pkg::TOK_EXEC) ? vis_next : vis_reg;
                end
            end
            ST_WALK:
            begin
                // one stored argument per cycle
                attr_next = sgr_apply(attr_reg, 32'(arg_reg[wi_reg]));
                if (CNT_W'(wi_reg) + 1'b1 == wcnt_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    wi_next = wi_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = ace_pkg::STATUS_EXEC;
                    orow_next    = row_reg;
                    ocol_next    = col_reg;
                    oattr_next   = attr_reg;
                    ovis_next    = vis_reg;
                    oclr_next    = ace_pkg::CLR_NONE;
                    orep_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            row_reg    <= '0;
            col_reg    <= '0;
            attr_reg   <= ace_pkg::ATTR_RESET;
            vis_reg    <= 1'b1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            attr_reg   <= attr_next;
            vis_reg    <= (take && tok.kind == ace_pkg::TOK_EXEC) ? vis_next : vis_reg;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wi_reg      <= wi_next;
        wcnt_reg    <= wcnt_next;
        ostatus_reg <= ostatus_next;
        orow_reg    <= orow_next;
        ocol_reg    <= ocol_next;
        oattr_reg   <= oattr_next;
        ovis_reg    <= ovis_next;
        oclr_reg    <= oclr_next;
        orep_reg    <= orep_next;
        if (take && tok.we)
        begin
            arg_reg[tok.widx] <= tok.wval;
        end
    end

    assign result.valid          = ovalid_reg;
    assign result.status         = ostatus_reg;
    assign result.cursor_row     = orow_reg;
    assign result.cursor_col     = ocol_reg;
    assign result.text_attr      = oattr_reg;
    assign result.cursor_visible = ovis_reg;
    assign result.clear_op       = oclr_reg;
    assign result.report_valid   = orep_reg;
endmodule
`default_nettype wire

/* hw/rtl/ansi_csi_console_engine.sv */
// top level: parser, command queue, executor and screen size registers
// a non-sgr character's result is registered in the cycle after the executor takes it
// throughput: one character per cycle while the queue is not full; an sgr command passes
// through the executor's idle, walk and emit states, walking the stored arguments one per cycle
// reset: cursor at 0,0, attribute 0x07, cursor shown, 80 columns, 25 rows, parser idle
`default_nettype none
module ansi_csi_console_engine #(
    parameter int MAX_ARGS   = ace_pkg::MAX_ARGS_DEF,
    parameter int MAX_DIGITS = ace_pkg::MAX_DIGITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ace_cfg_if.sink      cfg,
    ace_char_if.sink     char_in,
    ace_result_if.source result
);
    localparam int IDX_W = $clog2(MAX_ARGS);
    localparam int CNT_W = $clog2(MAX_ARGS + 1);
    localparam int ARG_W = $clog2(10 ** MAX_DIGITS);
    localparam int TOK_W = 9 + IDX_W + ARG_W + CNT_W;

    ace_pkg::screen_cfg_t scr_reg;
    logic             push, full, pop, empty;
    logic [TOK_W-1:0] push_data, pop_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_reg.cols <= ace_pkg::COLS_RESET;
            scr_reg.rows <= ace_pkg::ROWS_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == ace_pkg::REG_COLUMNS)
            begin
                scr_reg.cols <= cfg.data;
            end
            else if (cfg.index == ace_pkg::REG_ROWS)
            begin
                scr_reg.rows <= cfg.data;
            end
        end
    end

    ace_front #(
        .MAX_ARGS   (MAX_ARGS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_in),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    ace_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (ace_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    ace_back #(
        .MAX_ARGS   (MAX_ARGS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (scr_reg),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty),
        .result   (result)
    );
endmodule
`default_nettype wire

/* verif/ace_console_checker.sv */
// checker for the console engine: watches all channels, predicts each result and compares
`timescale 1ns / 1ps
`default_nettype none
module ace_console_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    ace_cfg_if        cfg,
    ace_char_if       char_in,
    ace_result_if     result,
    output int        fail_count,
    output int        pending
);

    typedef enum int {AWAIT_BRACKET, PARAMS, DIGITS} parse_phase_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] cursor_row;
        logic [7:0] cursor_col;
        logic [6:0] text_attr;
        logic       cursor_visible;
        logic [2:0] clear_op;
        logic       report_valid;
    } console_result_t;

    console_result_t expected_results[$];

    parse_phase_t phase;
    int unsigned  arg_val[ace_pkg::MAX_ARGS_DEF];
    int unsigned  argc;
    int unsigned  digc;
    logic [1:0]   prefix;
    int unsigned  row, col;
    logic [6:0]   attr;
    logic         cursor_shown;
    int unsigned  cols, rows;

    assign pending = expected_results.size();

    function automatic logic [3:0] fg_code(int unsigned idx);
        case (idx)
            0: return 4'h0;
            1: return 4'h4;
            2: return 4'h2;
            3: return 4'he;
            4: return 4'h1;
            5: return 4'h5;
            6: return 4'h3;
            default: return 4'hf;
        endcase
    endfunction

    function automatic logic [2:0] bg_code(int unsigned idx);
        case (idx)
            0: return 3'd0;
            1: return 3'd4;
            2: return 3'd2;
            3: return 3'd6;
            4: return 3'd1;
            5: return 3'd5;
            6: return 3'd3;
            default: return 3'd7;
        endcase
    endfunction

    function automatic int unsigned arg_or_zero(int unsigned i);
        return i < ace_pkg::MAX_ARGS_DEF ? arg_val[i] : 0;
    endfunction

    function automatic void move_to(int unsigned c, int unsigned r);
        int unsigned ec, er;
        ec = cols == 0 ? 1 : cols;
        er = rows == 0 ? 1 : rows;
        if (c < ec && r < er)
        begin
            col = c;
            row = r;
        end
    endfunction

    function automatic void apply_graphics(int unsigned v);
        logic [6:0] a;
        a = attr;
        if (v == 0) a = ace_pkg::ATTR_RESET;
        else if (v == 1) a = a | 7'h08;
        else if (v == 2 || v == 22) a = a & ~7'h08;
        else if (v == 7 || v == 27) a = ~a;
        else if (v >= 30 && v <= 37) a = (a & 7'h78) | fg_code(v - 30);
        else if (v == 39) a = (a & 7'h70) | 7'h07;
        else if (v >= 40 && v <= 47) a = (a & 7'h0f) | {bg_code(v - 40), 4'h0};
        else if (v == 49) a = a & 7'h0f;
        else if (v >= 90 && v <= 97) a = (a & 7'h70) | 7'h08 | fg_code(v - 90);
        else if (v >= 100 && v <= 107) a = (a & 7'h0f) | {bg_code(v - 100), 4'h0};
        attr = a;
    endfunction

    function automatic logic [1:0] run_command(int unsigned c, output logic [2:0] clr,
                                               output logic rep);
        int unsigned d, code, lastc, lastr;
        d = 1;
        clr = ace_pkg::CLR_NONE;
        rep = 1'b0;
        lastc = (cols == 0 ? 1 : cols) - 1;
        lastr = (rows == 0 ? 1 : rows) - 1;
        if (c >= "A" && c <= "G")
        begin
            if (argc == 1) d = arg_or_zero(0);
            else if (argc != 0) return ace_pkg::STATUS_REJ;
        end
        case (c)
            "H", "f":
            begin
                if (argc == 0) move_to(0, 0);
                else if (argc == 2) move_to(arg_or_zero(1), arg_or_zero(0));
                else return ace_pkg::STATUS_REJ;
                return ace_pkg::STATUS_EXEC;
            end
            "A": move_to(col, row > d ? row - d : 0);
            "B": move_to(col, row + d < lastr ? row + d : lastr);
            "C": move_to(col + d < lastc ? col + d : lastc, row);
            "D": move_to(col > d ? col - d : 0, row);
            "E": move_to(0, row + d < lastr ? row + d : lastr);
            "F": move_to(0, row > d ? row - d : 0);
            "G":
            begin
                d = d > 0 ? d - 1 : 0;
                move_to(d < lastc ? d : lastc, row);
            end
            "J", "K":
            begin
                code = argc == 0 ? 0 : arg_or_zero(0);
                if (code > 2) return ace_pkg::STATUS_REJ;
                clr = 3'(code) + (c == "J" ? ace_pkg::CLR_SCR : ace_pkg::CLR_LN);
            end
            "m":
            begin
                if (argc == 0) return ace_pkg::STATUS_REJ;
                for (int unsigned i = 0; i < argc && i < ace_pkg::MAX_ARGS_DEF; i++)
                    apply_graphics(arg_val[i]);
            end
            "h", "l":
            begin
                if (prefix == ace_pkg::PREFIX_QUERY && argc == 1 && arg_or_zero(0) == 25)
                    cursor_shown = (c == "h");
            end
            "s", "u": ;
            "n":
            begin
                if (argc == 1 && arg_or_zero(0) == 6) rep = 1'b1;
                else return ace_pkg::STATUS_REJ;
            end
            default: return ace_pkg::STATUS_REJ;
        endcase
        return ace_pkg::STATUS_EXEC;
    endfunction

    function automatic void take_digit(int unsigned c);
        if (argc < ace_pkg::MAX_ARGS_DEF) arg_val[argc] = arg_val[argc] * 10 + (c - "0");
        digc++;
    endfunction

    function automatic console_result_t console_step(logic [15:0] ch);
        console_result_t r;
        int unsigned c;
        logic [1:0] st;
        logic [2:0] clr;
        logic rep;
        logic is_digit;
        c = ch;
        st = ace_pkg::STATUS_PEND;
        clr = ace_pkg::CLR_NONE;
        rep = 1'b0;
        is_digit = (c >= "0" && c <= "9");
        if (c != 0)
        begin
            case (phase)
                AWAIT_BRACKET:
                begin
                    if (c == "[") phase = PARAMS;
                    else st = ace_pkg::STATUS_REJ;
                end
                PARAMS:
                begin
                    if (is_digit)
                    begin
                        phase = DIGITS;
                        digc = 0;
                        if (argc < ace_pkg::MAX_ARGS_DEF) arg_val[argc] = 0;
                        take_digit(c);
                    end
                    else if (c == "?") prefix = ace_pkg::PREFIX_QUERY;
                    else if (c == "=") prefix = ace_pkg::PREFIX_EQ;
                    else st = run_command(c, clr, rep);
                end
                default:
                begin
                    if (is_digit)
                    begin
                        if (digc < ace_pkg::MAX_DIGITS_DEF) take_digit(c);
                        else st = ace_pkg::STATUS_REJ;
                    end
                    else if (c == ";")
                    begin
                        digc = 0;
                        argc++;
                        if (argc >= ace_pkg::MAX_ARGS_DEF) st = ace_pkg::STATUS_REJ;
                        else arg_val[argc] = 0;
                    end
                    else
                    begin
                        argc++;
                        if (argc < ace_pkg::MAX_ARGS_DEF) arg_val[argc] = 0;
                        st = run_command(c, clr, rep);
                    end
                end
            endcase
            if (st != ace_pkg::STATUS_PEND)
            begin
                phase = AWAIT_BRACKET;
                argc = 0;
                digc = 0;
                prefix = ace_pkg::PREFIX_NONE;
            end
        end
        r.status = st;
        r.cursor_row = row[7:0];
        r.cursor_col = col[7:0];
        r.text_attr = attr;
        r.cursor_visible = cursor_shown;
        r.clear_op = clr;
        r.report_valid = rep;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase <= AWAIT_BRACKET;
            argc <= 0;
            digc <= 0;
            prefix <= ace_pkg::PREFIX_NONE;
            row <= 0;
            col <= 0;
            attr <= ace_pkg::ATTR_RESET;
            cursor_shown <= 1'b1;
            cols <= ace_pkg::COLS_RESET;
            rows <= ace_pkg::ROWS_RESET;
            fail_count <= 0;
            expected_results.delete();
            for (int i = 0; i < ace_pkg::MAX_ARGS_DEF; i++)
                arg_val[i] <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == ace_pkg::REG_COLUMNS) cols = cfg.data;
                else if (cfg.index == ace_pkg::REG_ROWS) rows = cfg.data;
            end
            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end
                else
                begin
                    console_result_t e;
                    e = expected_results.pop_front();
                    if (e.status !== result.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, result.status);
                        fail_count++;
                    end
                    if (e.cursor_row !== result.cursor_row)
                    begin
                        $error("cursor_row: expected %0d, got %0d", e.cursor_row,
                               result.cursor_row);
                        fail_count++;
                    end
                    if (e.cursor_col !== result.cursor_col)
                    begin
                        $error("cursor_col: expected %0d, got %0d", e.cursor_col,
                               result.cursor_col);
                        fail_count++;
                    end
                    if (e.text_attr !== result.text_attr)
                    begin
                        $error("text_attr: expected 0x%0h, got 0x%0h", e.text_attr,
                               result.text_attr);
                        fail_count++;
                    end
                    if (e.cursor_visible !== result.cursor_visible)
                    begin
                        $error("cursor_visible: expected %0d, got %0d", e.cursor_visible,
                               result.cursor_visible);
                        fail_count++;
                    end
                    if (e.clear_op !== result.clear_op)
                    begin
                        $error("clear_op: expected %0d, got %0d", e.clear_op,
                               result.clear_op);
                        fail_count++;
                    end
                    if (e.report_valid !== result.report_valid)
                    begin
                        $error("report_valid: expected %0d, got %0d", e.report_valid,
                               result.report_valid);
                        fail_count++;
                    end
                end
            end
            if (char_in.valid && char_in.ready)
                expected_results.push_back(console_step(char_in.ch));
        end
    end

endmodule
`default_nettype wire

/* verif/tb_ansi_csi_console_engine.sv */
// testbench top: clock, reset, character and configuration stimulus, verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_ansi_csi_console_engine;

    localparam string COMMAND_LETTERS = "HABCDEFGsuJKmlhfn";
    localparam int    ITEM_TARGET     = 1550;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   chars_sent;
    bit   quiet;
    bit   hold_req;

    ace_cfg_if    cfg();
    ace_char_if   char_in();
    ace_result_if result();

    ansi_csi_console_engine i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .char_in (char_in),
        .result  (result)
    );

    ace_console_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .char_in    (char_in),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("ansi_csi_console_engine verification failed");
        $finish;
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                result.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                result.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_ch(input logic [15:0] c);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            char_in.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        char_in.valid <= 1'b1;
        char_in.ch <= c;
        @(posedge clk);
        while (!char_in.ready) @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_ch(16'(s[i]));
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        char_in.valid <= 1'b0;
        // let the checker record the last accepted character first
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int unsigned pick_arg();
        int unsigned k;
        k = $urandom_range(0, 9);
        case (k)
            0, 1: return $urandom_range(0, 9);
            2, 3: return $urandom_range(0, 300);
            4, 5: return $urandom_range(0, 1) ? $urandom_range(30, 49)
                                               : $urandom_range(90, 107);
            6: return $urandom_range(0, 2) == 0 ? 25 : 6;
            7: return $urandom_range(0, 1) ? 9999 : $urandom_range(1000, 9999);
            8: return $urandom_range(10000, 99999);
            default: return $urandom_range(0, 27);
        endcase
    endfunction

    task automatic random_sequence();
        int unsigned r, nargs, k;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            send_ch(16'($urandom));
            return;
        end
        if (r < 9)
        begin
            send_ch(16'h0000);
            return;
        end
        if (r < 14)
        begin
            send_text("[?25");
            send_text($urandom_range(0, 1) ? "h" : "l");
            return;
        end
        send_ch("[");
        if (r < 20)
        begin
            send_ch(16'($urandom));
            return;
        end
        if ($urandom_range(0, 3) == 0)
            send_ch($urandom_range(0, 2) == 0 ? "=" : "?");
        k = $urandom_range(0, 19);
        nargs = k < 14 ? $urandom_range(0, 3) : (k < 18 ? $urandom_range(4, 8)
                                                        : $urandom_range(13, 16));
        for (int unsigned i = 0; i < nargs; i++)
        begin
            if (i != 0) send_ch(";");
            if ($urandom_range(0, 11) != 0)
                send_text($sformatf("%0d", pick_arg()));
            else if (i == 0 && nargs > 1)
                send_ch("0");
        end
        if ($urandom_range(0, 12) == 0)
            send_ch(16'($urandom_range(0, 1) ? $urandom : $urandom_range(32, 126)));
        else
            send_ch(16'(COMMAND_LETTERS[$urandom_range(0, COMMAND_LETTERS.len() - 1)]));
    endtask

    initial
    begin
        rst_n = 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        chars_sent = 0;
        char_in.valid = 1'b0;
        char_in.ch = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: edges of every command and special case
        send_text("x[H[9999;9999H[3;7f[A[200B[C[999D[E[2F[G[0G[300G");
        send_text("[J[1J[2J[3K[0;1;7;31;44;92;105;2;27;39;49;22m[m");
        send_text("[?25l[=25h[?25h[6n[5n[s[u[12345[1;2;3;4;5;6;7;8;9;1;2;3;4;5;6m");
        send_text("[;5H[2;H[7;q[3?[1;2;3A");
        send_ch(16'hffff);
        send_ch(16'h0000);
        send_ch(16'h8000);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(ace_pkg::REG_COLUMNS, 8'd1);
                    write_reg(ace_pkg::REG_ROWS, 8'd1);
                end
                1:
                begin
                    write_reg(ace_pkg::REG_COLUMNS, 8'd255);
                    write_reg(ace_pkg::REG_ROWS, 8'd255);
                end
                2:
                begin
                    write_reg(ace_pkg::REG_COLUMNS, 8'd255);
                    write_reg(ace_pkg::REG_ROWS, 8'd1);
                end
                3:
                begin
                    write_reg(ace_pkg::REG_COLUMNS, 8'($urandom_range(1, 255)));
                    write_reg(ace_pkg::REG_ROWS, 8'($urandom_range(1, 255)));
                end
                4:
                begin
                    write_reg(ace_pkg::REG_COLUMNS, 8'd2);
                    write_reg(ace_pkg::REG_ROWS, 8'd200);
                end
                default:
                begin
                    write_reg(ace_pkg::REG_COLUMNS, ace_pkg::COLS_RESET);
                    write_reg(ace_pkg::REG_ROWS, ace_pkg::ROWS_RESET);
                    quiet = 1'b1;
                end
            endcase
            if (ph == 1)
                hold_req = 1'b1;
            while (chars_sent < (ph + 1) * ITEM_TARGET / 6)
                random_sequence();
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("ansi_csi_console_engine verification clean");
        else
            $display("ansi_csi_console_engine verification failed");
        $finish;
    end

endmodule
`default_nettype wire
